@@ design/pls_pkg.sv @@
package pls_pkg;

    // fixed field widths
    localparam int DIST_W    = 8;
    localparam int CUR_W     = 24;
    localparam int TOT_W     = 29;
    localparam int IDX_OUT_W = 5;
    localparam int CNT_OUT_W = 6;
    localparam int PROD_W    = CUR_W + TOT_W;

    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL = 1'd1;

    // result kinds
    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // request to the shared multiply-divide unit
    typedef struct packed {
        logic             start;
        logic [CUR_W-1:0] mult_a;
        logic [TOT_W-1:0] mult_b;
        logic [TOT_W-1:0] divisor;
    } md_req_t;

    // status of the shared multiply-divide unit
    typedef struct packed {
        logic idle;
        logic done;
    } md_stat_t;

    // saturating add of two totals
    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOT_W] ? TOT_MAX : s[TOT_W-1:0];
    endfunction

endpackage

@@ design/pls_if.sv @@
// building readings
interface pls_in_if;
    import pls_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] district;
    logic [CUR_W-1:0]  consumption;
    logic [CUR_W-1:0]  max_current;
    logic              last_building;

    modport source (output valid, output district, output consumption,
                    output max_current, output last_building, input ready);
    modport sink   (input valid, input district, input consumption,
                    input max_current, input last_building, output ready);
endinterface

// reports and summaries
interface pls_out_if;
    import pls_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [DIST_W-1:0]    district_out;
    logic [IDX_OUT_W-1:0] building_index;
    logic [CUR_W-1:0]     old_consumption;
    logic [CUR_W-1:0]     new_consumption;
    logic [TOT_W-1:0]     district_total;
    logic [CNT_OUT_W-1:0] over_count;
    logic                 over_budget;
    logic                 end_of_run;

    modport source (output valid, output kind, output district_out,
                    output building_index, output old_consumption,
                    output new_consumption, output district_total,
                    output over_count, output over_budget, output end_of_run,
                    input ready);
    modport sink   (input valid, input kind, input district_out,
                    input building_index, input old_consumption,
                    input new_consumption, input district_total,
                    input over_count, input over_budget, input end_of_run,
                    output ready);
endinterface

// register writes
interface pls_cfg_if;
    import pls_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TOT_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/pls_ram.sv @@
module pls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/pls_muldiv.sv @@
module pls_muldiv (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pls_pkg::md_req_t                req,
    output pls_pkg::md_stat_t               stat,
    output logic [pls_pkg::PROD_W-1:0]      quotient
);
    import pls_pkg::*;

    localparam int STEP_W = $clog2(PROD_W);

    typedef enum logic [1:0] {
        MD_IDLE = 2'b01,
        MD_DIV  = 2'b10
    } md_state_t;

    md_state_t         state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [TOT_W-1:0]  rem_reg, rem_next;
    logic [TOT_W-1:0]  div_reg, div_next;
    logic [TOT_W:0]    trial;
    logic              fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[PROD_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    // product lands in the dividend shifter
                    quo_next   = PROD_W'(req.mult_a) * PROD_W'(req.mult_b);
                    rem_next   = '0;
                    div_next   = req.divisor;
                    step_next  = '0;
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                rem_next = fits ? TOT_W'(trial - {1'b0, div_reg}) : trial[TOT_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], fits};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(PROD_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign stat.idle = (state_reg == MD_IDLE);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

@@ design/proportional_load_shedding.sv @@
// Proportional load shedding for one district. Buildings arrive one transaction
// at a time on the building channel, each with its Q16.8 consumption and limit;
// a building that is not the last gives no result, and buildings beyond
// MAX_BUILDINGS are dropped (their last mark still closes the run). On the last
// building the district total is checked against the budget: within budget, one
// summary follows. Over budget, one shared multiply and bit-serial divide unit
// runs two passes over the stored buildings: the first finds each allowance
// limit*budget/max_total and the excess, the second works out each cut as
// excess*(total-budget)/excess_total and sends a report per reduced building,
// then a summary. No item is taken while a run is being regulated. Registers are
// written by the cfg channel; the user must write them only while the block is
// idle, which the block itself does not enforce. A max total of zero counts as
// one. No clearing pass at reset.
module proportional_load_shedding #(
    parameter int MAX_BUILDINGS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    pls_in_if.sink    building,
    pls_out_if.source report,
    pls_cfg_if.sink   cfg
);
    import pls_pkg::*;

    // store address and count widths
    localparam int IDX_W = (MAX_BUILDINGS > 1) ? $clog2(MAX_BUILDINGS) : 1;
    localparam int CNT_W = $clog2(MAX_BUILDINGS + 1);

    // sequencer
    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_CHECK   = 10'b00_0000_0010,
        S_RD1     = 10'b00_0000_0100,
        S_MUL1    = 10'b00_0000_1000,
        S_WAIT1   = 10'b00_0001_0000,
        S_RD2     = 10'b00_0010_0000,
        S_CHK2    = 10'b00_0100_0000,
        S_WAIT2   = 10'b00_1000_0000,
        S_EMIT    = 10'b01_0000_0000,
        S_SUMMARY = 10'b10_0000_0000
    } state_t;

    state_t            state_reg, state_next;

    // batch bookkeeping
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [TOT_W-1:0]  excess_total_reg, excess_total_next;
    logic [TOT_W-1:0]  new_total_reg, new_total_next;
    logic [TOT_W-1:0]  diff_reg, diff_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  cut_reg, cut_next;
    logic              over_reg, over_next;
    logic [DIST_W-1:0] district_reg, district_next;
    logic [CUR_W-1:0]  cur_cons_reg, cur_cons_next;
    logic [CUR_W-1:0]  cur_new_reg, cur_new_next;

    // configuration
    logic [TOT_W-1:0]  budget_reg;
    logic [TOT_W-1:0]  max_total_reg;
    logic [TOT_W-1:0]  max_div;

    // output stage
    logic                 out_valid_reg, out_valid_next;
    logic                 out_kind_reg, out_kind_next;
    logic [DIST_W-1:0]    out_dist_reg, out_dist_next;
    logic [IDX_OUT_W-1:0] out_idx_reg, out_idx_next;
    logic [CUR_W-1:0]     out_old_reg, out_old_next;
    logic [CUR_W-1:0]     out_new_reg, out_new_next;
    logic [TOT_W-1:0]     out_total_reg, out_total_next;
    logic [CNT_OUT_W-1:0] out_cnt_reg, out_cnt_next;
    logic                 out_over_reg, out_over_next;
    logic                 out_end_reg, out_end_next;
    logic                 slot_free;
    logic                 in_accept;

    // building store: {limit, consumption}
    logic                 bld_wr_en;
    logic                 bld_rd_en;
    logic [2*CUR_W-1:0]   bld_rd_data;
    logic [CUR_W-1:0]     rd_cons;
    logic [CUR_W-1:0]     rd_limit;

    // excess store, zero for buildings within allowance
    logic                 exc_wr_en;
    logic [CUR_W-1:0]     exc_wr_data;
    logic                 exc_rd_en;
    logic [CUR_W-1:0]     exc_rd_data;

    // shared multiply-divide unit
    md_req_t              md_req;
    md_stat_t             md_stat;
    logic [PROD_W-1:0]    md_quo;

    assign building.ready = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign in_accept      = building.valid && building.ready;
    assign slot_free      = !out_valid_reg || report.ready;
    assign max_div        = (max_total_reg == '0) ? TOT_W'(1) : max_total_reg;
    assign idx_inc        = idx_reg + CNT_W'(1);
    assign rd_cons        = bld_rd_data[CUR_W-1:0];
    assign rd_limit       = bld_rd_data[2*CUR_W-1:CUR_W];

    pls_ram #(
        .WIDTH (2 * CUR_W),
        .DEPTH (MAX_BUILDINGS)
    ) u_bld_ram (
        .clk     (clk),
        .wr_en   (bld_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data ({building.max_current, building.consumption}),
        .rd_en   (bld_rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (bld_rd_data)
    );

    pls_ram #(
        .WIDTH (CUR_W),
        .DEPTH (MAX_BUILDINGS)
    ) u_exc_ram (
        .clk     (clk),
        .wr_en   (exc_wr_en),
        .wr_addr (idx_reg[IDX_W-1:0]),
        .wr_data (exc_wr_data),
        .rd_en   (exc_rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (exc_rd_data)
    );

    pls_muldiv u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (md_req),
        .stat     (md_stat),
        .quotient (md_quo)
    );

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        total_next        = total_reg;
        excess_total_next = excess_total_reg;
        new_total_next    = new_total_reg;
        diff_next         = diff_reg;
        idx_next          = idx_reg;
        cut_next          = cut_reg;
        over_next         = over_reg;
        district_next     = district_reg;
        cur_cons_next     = cur_cons_reg;
        cur_new_next      = cur_new_reg;

        // output stage empties when the sink takes the transaction
        out_valid_next = out_valid_reg && !report.ready;
        out_kind_next  = out_kind_reg;
        out_dist_next  = out_dist_reg;
        out_idx_next   = out_idx_reg;
        out_old_next   = out_old_reg;
        out_new_next   = out_new_reg;
        out_total_next = out_total_reg;
        out_cnt_next   = out_cnt_reg;
        out_over_next  = out_over_reg;
        out_end_next   = out_end_reg;

        bld_wr_en   = 1'b0;
        bld_rd_en   = 1'b0;
        exc_wr_en   = 1'b0;
        exc_wr_data = '0;
        exc_rd_en   = 1'b0;
        md_req      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    // store while there is room; a full store drops the building
                    if (count_reg < CNT_W'(MAX_BUILDINGS))
                    begin
                        bld_wr_en  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        total_next = sat_add(total_reg, TOT_W'(building.consumption));
                    end
                    if (building.last_building)
                    begin
                        district_next = building.district;
                        state_next    = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                cut_next = '0;
                if (total_reg <= budget_reg)
                begin
                    // within budget: summary only
                    new_total_next = total_reg;
                    over_next      = 1'b0;
                    state_next     = S_SUMMARY;
                end
                else
                begin
                    excess_total_next = '0;
                    new_total_next    = '0;
                    over_next         = 1'b1;
                    idx_next          = '0;
                    state_next        = S_RD1;
                end
            end
            S_RD1:
            begin
                bld_rd_en  = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                // allowance = limit * budget / max total
                md_req.start   = 1'b1;
                md_req.mult_a  = rd_limit;
                md_req.mult_b  = budget_reg;
                md_req.divisor = max_div;
                cur_cons_next  = rd_cons;
                state_next     = S_WAIT1;
            end
            S_WAIT1:
            begin
                if (md_stat.done)
                begin
                    exc_wr_en = 1'b1;
                    if (PROD_W'(cur_cons_reg) > md_quo)
                    begin
                        exc_wr_data       = cur_cons_reg - md_quo[CUR_W-1:0];
                        excess_total_next = sat_add(excess_total_reg,
                                                    TOT_W'(exc_wr_data));
                    end
                    else
                    begin
                        new_total_next = sat_add(new_total_reg, TOT_W'(cur_cons_reg));
                    end
                    if (idx_inc == count_reg)
                    begin
                        idx_next   = '0;
                        diff_next  = total_reg - budget_reg;
                        state_next = S_RD2;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_RD1;
                    end
                end
            end
            S_RD2:
            begin
                bld_rd_en  = 1'b1;
                exc_rd_en  = 1'b1;
                state_next = S_CHK2;
            end
            S_CHK2:
            begin
                cur_cons_next = rd_cons;
                if (exc_rd_data == '0 || excess_total_reg == '0)
                begin
                    // within allowance: no cut, no report
                    idx_next   = idx_inc;
                    state_next = (idx_inc == count_reg) ? S_SUMMARY : S_RD2;
                end
                else
                begin
                    // cut = excess * (total - budget) / excess total
                    md_req.start   = 1'b1;
                    md_req.mult_a  = exc_rd_data;
                    md_req.mult_b  = diff_reg;
                    md_req.divisor = excess_total_reg;
                    state_next     = S_WAIT2;
                end
            end
            S_WAIT2:
            begin
                if (md_stat.done)
                begin
                    // a cut at or above the consumption leaves nothing
                    cur_new_next = (md_quo >= PROD_W'(cur_cons_reg)) ? '0
                                   : cur_cons_reg - md_quo[CUR_W-1:0];
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_REPORT;
                    out_dist_next  = district_reg;
                    out_idx_next   = IDX_OUT_W'(idx_reg);
                    out_old_next   = cur_cons_reg;
                    out_new_next   = cur_new_reg;
                    out_total_next = '0;
                    out_cnt_next   = '0;
                    out_over_next  = 1'b1;
                    out_end_next   = 1'b0;
                    cut_next       = cut_reg + CNT_W'(1);
                    new_total_next = sat_add(new_total_reg, TOT_W'(cur_new_reg));
                    idx_next       = idx_inc;
                    state_next     = (idx_inc == count_reg) ? S_SUMMARY : S_RD2;
                end
            end
            S_SUMMARY:
            begin
                if (slot_free)
                begin
                    out_valid_next    = 1'b1;
                    out_kind_next     = KIND_SUMMARY;
                    out_dist_next     = district_reg;
                    out_idx_next      = '0;
                    out_old_next      = '0;
                    out_new_next      = '0;
                    out_total_next    = new_total_reg;
                    out_cnt_next      = CNT_OUT_W'(cut_reg);
                    out_over_next     = over_reg;
                    out_end_next      = 1'b1;
                    // run closed: batch state back to empty
                    count_next        = '0;
                    total_next        = '0;
                    excess_total_next = '0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            total_reg        <= '0;
            excess_total_reg <= '0;
            out_valid_reg    <= 1'b0;
            budget_reg       <= '0;
            max_total_reg    <= TOT_W'(1);
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            total_reg        <= total_next;
            excess_total_reg <= excess_total_next;
            out_valid_reg    <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_BUDGET:    budget_reg    <= cfg.data;
                    REG_MAX_TOTAL: max_total_reg <= cfg.data;
                    default:       budget_reg    <= budget_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        new_total_reg <= new_total_next;
        diff_reg      <= diff_next;
        idx_reg       <= idx_next;
        cut_reg       <= cut_next;
        over_reg      <= over_next;
        district_reg  <= district_next;
        cur_cons_reg  <= cur_cons_next;
        cur_new_reg   <= cur_new_next;
        out_kind_reg  <= out_kind_next;
        out_dist_reg  <= out_dist_next;
        out_idx_reg   <= out_idx_next;
        out_old_reg   <= out_old_next;
        out_new_reg   <= out_new_next;
        out_total_reg <= out_total_next;
        out_cnt_reg   <= out_cnt_next;
        out_over_reg  <= out_over_next;
        out_end_reg   <= out_end_next;
    end

    assign report.valid           = out_valid_reg;
    assign report.kind            = out_kind_reg;
    assign report.district_out    = out_dist_reg;
    assign report.building_index  = out_idx_reg;
    assign report.old_consumption = out_old_reg;
    assign report.new_consumption = out_new_reg;
    assign report.district_total  = out_total_reg;
    assign report.over_count      = out_cnt_reg;
    assign report.over_budget     = out_over_reg;
    assign report.end_of_run      = out_end_reg;

`ifndef ASSERT_OFF
    // the divider is only started when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        md_req.start |-> md_stat.idle)
        else $error("divider started while busy");

    // a finished division is only ever awaited in a wait state
    assert property (@(posedge clk) disable iff (!rst_n)
        md_stat.done |-> (state_reg == S_WAIT1 || state_reg == S_WAIT2))
        else $error("division finished outside a wait state");

    // the last building of a district starts the budget check
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && building.last_building) |=> (state_reg == S_CHECK))
        else $error("last building did not start the check");

    // a run being checked always holds at least one building
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (count_reg != '0))
        else $error("check with an empty store");
`endif

endmodule

@@ bench/shed_checker.sv @@
`timescale 1ns / 100ps

module shed_checker #(
    parameter int MAX_BUILDINGS = 32
) (
    input  logic clk,
    input  logic rst_n,
    pls_in_if    building,
    pls_out_if   report,
    pls_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding
);
    import pls_pkg::*;

    localparam int PRINT_LIMIT = 50;

    typedef struct {
        logic                 kind;
        logic [DIST_W-1:0]    district;
        logic [IDX_OUT_W-1:0] index;
        logic [CUR_W-1:0]     old_cons;
        logic [CUR_W-1:0]     new_cons;
        logic [TOT_W-1:0]     total;
        logic [CNT_OUT_W-1:0] count;
        logic                 over;
        logic                 closing;
    } shed_result_t;

    logic [TOT_W-1:0] budget;
    logic [TOT_W-1:0] max_total;
    logic [CUR_W-1:0] cons_mem  [MAX_BUILDINGS];
    logic [CUR_W-1:0] limit_mem [MAX_BUILDINGS];
    int               stored;
    logic [TOT_W-1:0] load_sum;
    shed_result_t     due_results [$];
    int               errors = 0;

    function automatic logic [TOT_W-1:0] clip_sum(input logic [TOT_W-1:0] a,
                                                  input logic [63:0] b);
        logic [63:0] s;
        s = 64'(a) + b;
        return (s > 64'(TOT_MAX)) ? TOT_MAX : s[TOT_W-1:0];
    endfunction

    function automatic shed_result_t pack_result(input logic kind,
                                                 input logic [DIST_W-1:0] district_id,
                                                 input logic [IDX_OUT_W-1:0] idx,
                                                 input logic [CUR_W-1:0] oldc,
                                                 input logic [CUR_W-1:0] newc,
                                                 input logic [TOT_W-1:0] tot,
                                                 input logic [CNT_OUT_W-1:0] cnt,
                                                 input logic over,
                                                 input logic closing);
        shed_result_t r;
        r.kind     = kind;
        r.district = district_id;
        r.index    = idx;
        r.old_cons = oldc;
        r.new_cons = newc;
        r.total    = tot;
        r.count    = cnt;
        r.over     = over;
        r.closing  = closing;
        return r;
    endfunction

    // closes a district: within budget, or proportional cuts then a summary
    function automatic void regulate_district(input logic [DIST_W-1:0] district_id);
        logic [63:0]      allow [MAX_BUILDINGS];
        logic [63:0]      divisor;
        logic [63:0]      overshoot;
        logic [63:0]      cut;
        logic [63:0]      left;
        logic [TOT_W-1:0] excess_sum;
        logic [TOT_W-1:0] kept_sum;
        int               n_cut;
        if (load_sum <= budget) begin
            due_results.push_back(pack_result(KIND_SUMMARY, district_id, '0, '0, '0,
                                              load_sum, '0, 1'b0, 1'b1));
        end else begin
            divisor    = (max_total == '0) ? 64'd1 : 64'(max_total);
            excess_sum = '0;
            kept_sum   = '0;
            n_cut      = 0;
            for (int i = 0; i < stored; i++) begin
                allow[i] = (64'(limit_mem[i]) * 64'(budget)) / divisor;
                if (64'(cons_mem[i]) > allow[i])
                    excess_sum = clip_sum(excess_sum, 64'(cons_mem[i]) - allow[i]);
                else
                    kept_sum = clip_sum(kept_sum, 64'(cons_mem[i]));
            end
            overshoot = 64'(load_sum) - 64'(budget);
            for (int i = 0; i < stored; i++) begin
                if (64'(cons_mem[i]) > allow[i] && excess_sum != '0) begin
                    cut  = ((64'(cons_mem[i]) - allow[i]) * overshoot) / 64'(excess_sum);
                    left = (cut >= 64'(cons_mem[i])) ? 64'd0 : 64'(cons_mem[i]) - cut;
                    due_results.push_back(pack_result(KIND_REPORT, district_id,
                                                      IDX_OUT_W'(i),
                                                      cons_mem[i], left[CUR_W-1:0], '0,
                                                      '0, 1'b1, 1'b0));
                    n_cut++;
                    kept_sum = clip_sum(kept_sum, left);
                end
            end
            due_results.push_back(pack_result(KIND_SUMMARY, district_id, '0, '0, '0,
                                              kept_sum, CNT_OUT_W'(n_cut), 1'b1, 1'b1));
        end
        stored   = 0;
        load_sum = '0;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        shed_result_t seen;
        shed_result_t want;
        if (!rst_n) begin
            budget    = '0;
            max_total = TOT_W'(1);
            stored    = 0;
            load_sum  = '0;
            due_results.delete();
            mismatches  <= errors;
            outstanding <= 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == REG_BUDGET)
                    budget = cfg.data;
                else if (cfg.index == REG_MAX_TOTAL)
                    max_total = cfg.data;
            end
            if (building.valid && building.ready) begin
                // a full store drops the building, but its last mark still counts
                if (stored < MAX_BUILDINGS) begin
                    cons_mem[stored]  = building.consumption;
                    limit_mem[stored] = building.max_current;
                    stored++;
                    load_sum = clip_sum(load_sum, 64'(building.consumption));
                end
                if (building.last_building)
                    regulate_district(building.district);
            end
            if (report.valid && report.ready) begin
                seen = pack_result(report.kind, report.district_out, report.building_index,
                                   report.old_consumption, report.new_consumption,
                                   report.district_total, report.over_count,
                                   report.over_budget, report.end_of_run);
                if (due_results.size() == 0) begin
                    errors++;
                    if (errors <= PRINT_LIMIT)
                        $display("%0t: unexpected result, expected none, actual kind %0d",
                                 $time, seen.kind);
                end else begin
                    want = due_results.pop_front();
                    compare_field("kind", 64'(want.kind), 64'(seen.kind));
                    compare_field("district_out", 64'(want.district), 64'(seen.district));
                    compare_field("building_index", 64'(want.index), 64'(seen.index));
                    compare_field("old_consumption", 64'(want.old_cons),
                                  64'(seen.old_cons));
                    compare_field("new_consumption", 64'(want.new_cons),
                                  64'(seen.new_cons));
                    compare_field("district_total", 64'(want.total), 64'(seen.total));
                    compare_field("over_count", 64'(want.count), 64'(seen.count));
                    compare_field("over_budget", 64'(want.over), 64'(seen.over));
                    compare_field("end_of_run", 64'(want.closing), 64'(seen.closing));
                end
            end
            mismatches  <= errors;
            outstanding <= due_results.size();
        end
    end

endmodule

@@ bench/proportional_load_shedding_test.sv @@
`timescale 1ns / 100ps

module proportional_load_shedding_test;
    import pls_pkg::*;

    localparam int N_BUILDINGS   = 32;
    localparam int ITEM_TARGET   = 420;
    // longest quiet spell: a full store over budget, plus stalls
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 100;

    // how the budget and max total are set ahead of a district
    typedef enum int {
        KEEP_SETTING,
        SCALE_TO_LOAD,
        ROOM_TO_SPARE,
        ANY_SETTING,
        EDGE_SETTING,
        STARVED
    } setting_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   quiet;
    int   sent;
    int   stall_cycles;
    int   mismatches;
    int   outstanding;

    pls_in_if  building ();
    pls_out_if report ();
    pls_cfg_if cfg ();

    proportional_load_shedding #(
        .MAX_BUILDINGS(N_BUILDINGS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .building (building),
        .report   (report),
        .cfg      (cfg)
    );

    shed_checker #(
        .MAX_BUILDINGS(N_BUILDINGS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .building    (building),
        .report      (report),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // result side back-pressure, switched off during the quiet stretch
    always @(posedge clk)
    begin
        report.ready <= rst_n && (quiet || $urandom_range(99) >= 6);
    end

    // watchdog: ends the run when no transaction moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (building.valid && building.ready) || (report.valid && report.ready)
            || (cfg.valid && cfg.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[proportional_load_shedding] ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one building transaction; valid stays high afterwards unless the next call idles
    task automatic send_building(input logic [DIST_W-1:0] district_id,
                                 input logic [CUR_W-1:0] cons,
                                 input logic [CUR_W-1:0] lim,
                                 input logic last);
        while (!quiet && $urandom_range(99) < 6)
        begin
            building.valid <= 1'b0;
            @(posedge clk);
        end
        building.valid         <= 1'b1;
        building.district      <= district_id;
        building.consumption   <= cons;
        building.max_current   <= lim;
        building.last_building <= last;
        @(posedge clk);
        while (!building.ready)
            @(posedge clk);
        sent++;
    endtask

    // hold the sender until every expected result is back, then let the block settle
    task automatic wait_idle();
        building.valid <= 1'b0;
        // the checker's count is registered behind the transaction that fed it
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOT_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    // registers only change with the block idle
    task automatic set_budget(input logic [TOT_W-1:0] budget, input logic [TOT_W-1:0] scale);
        wait_idle();
        write_reg(REG_BUDGET, budget);
        write_reg(REG_MAX_TOTAL, scale);
        cfg.valid <= 1'b0;
    endtask

    // meter reading: all-zero and all-ones often, otherwise small, 20-bit or full range
    function automatic logic [CUR_W-1:0] pick_reading(input int shape);
        int roll;
        roll = $urandom_range(7);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        case (shape)
            0: return CUR_W'($urandom_range(255));
            1: return CUR_W'($urandom_range(20'hFFFFF));
            default: return CUR_W'($urandom);
        endcase
    endfunction

    function automatic logic [TOT_W-1:0] clip_total(input logic [63:0] v);
        return (v > 64'(TOT_MAX)) ? TOT_MAX : v[TOT_W-1:0];
    endfunction

    function automatic logic [TOT_W-1:0] pick_extreme();
        case ($urandom_range(2))
            0: return '0;
            1: return TOT_W'(1);
            default: return TOT_MAX;
        endcase
    endfunction

    // one district: n buildings of random readings, the last one marked
    task automatic run_district(input int n, input setting_e setting);
        logic [CUR_W-1:0]  cons [$];
        logic [CUR_W-1:0]  lim [$];
        logic [DIST_W-1:0] district_id;
        logic [63:0]       load;
        logic [63:0]       limits;
        logic [63:0]       scale;
        int                shape;
        bit                scatter;
        shape       = $urandom_range(3);
        district_id = DIST_W'($urandom);
        scatter     = ($urandom_range(15) == 0);
        load        = '0;
        limits      = '0;
        for (int i = 0; i < n; i++)
        begin
            cons.push_back(pick_reading(shape));
            lim.push_back(pick_reading(shape));
            // only stored buildings count towards the total
            if (i < N_BUILDINGS)
            begin
                load   += 64'(cons[i]);
                limits += 64'(lim[i]);
            end
        end
        case (setting)
            SCALE_TO_LOAD:
            begin
                // max total near the sum of limits, budget at or below the load
                scale = limits - limits / 4 + 64'($urandom_range(32'(limits / 2)));
                set_budget(TOT_W'($urandom_range(32'(load))), clip_total(scale));
            end
            ROOM_TO_SPARE:
                set_budget(clip_total(load + 64'($urandom_range(4096))),
                           TOT_W'($urandom_range(1, 32'(TOT_MAX))));
            ANY_SETTING:
                set_budget(TOT_W'($urandom), TOT_W'($urandom));
            EDGE_SETTING:
                set_budget(pick_extreme(), pick_extreme());
            STARVED:
                // every allowance floors to zero, so every non-idle building is cut
                set_budget(TOT_W'(1), TOT_MAX);
            default: ;
        endcase
        for (int i = 0; i < n; i++)
            send_building(scatter ? DIST_W'($urandom) : district_id, cons[i], lim[i],
                          i == n - 1);
    endtask

    initial
    begin
        int       batch;
        int       roll;
        int       n;
        setting_e setting;

        building.valid         <= 1'b0;
        building.district      <= '0;
        building.consumption   <= '0;
        building.max_current   <= '0;
        building.last_building <= 1'b0;
        cfg.valid              <= 1'b0;
        cfg.index              <= REG_BUDGET;
        cfg.data               <= '0;
        quiet                  <= 1'b0;
        sent = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zero budget, an empty district is within budget
        send_building(8'd0, 24'd0, 24'd0, 1'b1);

        // largest budget with a zero max total, top district and readings
        set_budget(TOT_MAX, '0);
        send_building(8'hFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);

        // zero-limit building far over a tiny budget: the cut swallows it whole
        set_budget(TOT_W'(256), '0);
        send_building(8'hA5, 24'hFFFFFF, 24'd0, 1'b0);
        send_building(8'hA5, 24'h001000, 24'h000010, 1'b1);

        // over budget yet every building inside its allowance
        set_budget(TOT_W'(10), TOT_W'(1));
        send_building(8'h01, 24'd20, 24'd100, 1'b1);

        // mixed district: two reduced, one spared; district number varies
        set_budget(TOT_W'(1000), TOT_W'(3000));
        send_building(8'h07, 24'd600, 24'd1000, 1'b0);
        send_building(8'h70, 24'd200, 24'd1000, 1'b0);
        send_building(8'h5A, 24'd500, 24'd500, 1'b1);

        // largest max total, plenty of budget
        set_budget(TOT_MAX, TOT_MAX);
        send_building(8'h5A, 24'h123456, 24'h654321, 1'b1);

        // random districts: mostly small, a few that fill or overflow the store
        batch = 0;
        while (sent < ITEM_TARGET)
        begin
            roll = $urandom_range(99);
            if (batch == 0)
                run_district(N_BUILDINGS + 4, SCALE_TO_LOAD);
            else if (batch == 1)
                run_district(N_BUILDINGS, STARVED);
            else
            begin
                if (roll < 2)
                    n = $urandom_range(N_BUILDINGS + 8, N_BUILDINGS + 1);
                else if (roll < 10)
                    n = $urandom_range(N_BUILDINGS, 9);
                else
                    n = $urandom_range(8, 1);
                case ($urandom_range(9))
                    0, 1, 2, 3: setting = KEEP_SETTING;
                    4, 5, 6:    setting = SCALE_TO_LOAD;
                    7:          setting = ROOM_TO_SPARE;
                    8:          setting = ANY_SETTING;
                    default:    setting = EDGE_SETTING;
                endcase
                run_district(n, setting);
            end
            // a stretch with neither side idling
            if (batch == 10)
                quiet <= 1'b1;
            else if (batch == 25)
                quiet <= 1'b0;
            batch++;
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[proportional_load_shedding] OK");
        else
            $display("[proportional_load_shedding] ERROR");
        $finish;
    end

endmodule
